// ===== rtl/core/sgi_pkg.sv =====
`timescale 1ns / 1ps
package sgi_pkg;

    localparam int IN_W       = 32;
    localparam int OUT_W      = IN_W;
    localparam int BND_W      = IN_W + 1;
    localparam int DM_W       = IN_W + 1;         // |xx - yy|, |xy + yx|
    localparam int SQ_W       = 2 * IN_W - 1;     // single squares, ea, eb, |ea - eb|
    localparam int PR_W       = 2 * IN_W;         // signed cross products, |ec|, ea + eb
    localparam int EC_W       = 2 * IN_W + 1;     // signed ec
    localparam int IN_ROOT_W  = 2 * IN_W;
    localparam int IN_RAD_W   = 2 * IN_ROOT_W;
    localparam int OUT_ROOT_W = IN_W + 1;
    localparam int OUT_RAD_W  = 2 * OUT_ROOT_W;

    typedef struct packed {
        logic [OUT_W-1:0] dil;
        logic [OUT_W-1:0] rot;
    } t_lin;

    typedef struct packed {
        t_lin                 lin;
        logic [OUT_RAD_W-1:0] shear_rad;
        logic [PR_W-1:0]      sab;
    } t_side;

    typedef struct packed {
        logic [IN_ROOT_W+1:0] rem;
        logic [IN_ROOT_W-1:0] root;
    } t_in_acc;

    typedef struct packed {
        logic [OUT_ROOT_W+1:0] rem;
        logic [OUT_ROOT_W-1:0] root;
    } t_out_acc;

    // one restoring square-root digit: bring down two radicand bits, try root*4+1
    function automatic t_in_acc in_root_step(t_in_acc a, logic [1:0] pair);
        t_in_acc              r;
        logic [IN_ROOT_W+1:0] cur;
        logic [IN_ROOT_W+1:0] trial;
        cur   = {a.rem[IN_ROOT_W-1:0], pair};
        trial = {a.root, 2'b01};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {a.root[IN_ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {a.root[IN_ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_out_acc out_root_step(t_out_acc a, logic [1:0] pair);
        t_out_acc              r;
        logic [OUT_ROOT_W+1:0] cur;
        logic [OUT_ROOT_W+1:0] trial;
        cur   = {a.rem[OUT_ROOT_W-1:0], pair};
        trial = {a.root, 2'b01};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {a.root[OUT_ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {a.root[OUT_ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sgi_in_if.sv =====
`timescale 1ns / 1ps
interface sgi_in_if;
    import sgi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] grad_xx;
    logic signed [IN_W-1:0] grad_xy;
    logic signed [IN_W-1:0] grad_yx;
    logic signed [IN_W-1:0] grad_yy;
    modport source (output valid, grad_xx, grad_xy, grad_yx, grad_yy, input ready);
    modport sink (input valid, grad_xx, grad_xy, grad_yx, grad_yy, output ready);
endinterface

// ===== rtl/core/sgi_out_if.sv =====
`timescale 1ns / 1ps
interface sgi_out_if;
    import sgi_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] dilatation;
    logic signed [OUT_W-1:0] rotation;
    logic [OUT_W-1:0]        max_shear;
    logic [BND_W-1:0]        strain_bound;
    modport source (output valid, dilatation, rotation, max_shear, strain_bound, input ready);
    modport sink (input valid, dilatation, rotation, max_shear, strain_bound, output ready);
endinterface

// ===== rtl/core/sgi_front.sv =====
`timescale 1ns / 1ps
module sgi_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [sgi_pkg::IN_W-1:0] i_xx,
    input  logic signed [sgi_pkg::IN_W-1:0] i_xy,
    input  logic signed [sgi_pkg::IN_W-1:0] i_yx,
    input  logic signed [sgi_pkg::IN_W-1:0] i_yy,
    output logic                            o_valid,
    output sgi_pkg::t_side                  o_side,
    output logic [sgi_pkg::IN_RAD_W-1:0]    o_rad
);
    import sgi_pkg::*;

    localparam int NSTG = 7;

    logic [NSTG-1:0] r_v;

    // stage 1
    logic [IN_W:0] n_sum, n_rdf, n_d, n_s;
    logic [DM_W-1:0] n_dm, n_sm;
    t_lin r1_lin;
    logic [DM_W-1:0] r1_dm, r1_sm;
    logic signed [IN_W-1:0] r1_xx, r1_xy, r1_yx, r1_yy;

    // stage 2
    logic signed [PR_W-1:0] n_pxx, n_pxy, n_pyx, n_pyy;
    t_lin r2_lin;
    logic [OUT_RAD_W-1:0] r2_dm2, r2_sm2;
    logic [SQ_W-1:0] r2_xx2, r2_xy2, r2_yx2, r2_yy2;
    logic signed [PR_W-1:0] r2_pa, r2_pb;

    // stage 3
    logic [PR_W-1:0] n_ea2, n_eb2;
    t_lin r3_lin;
    logic [OUT_RAD_W-1:0] r3_srad;
    logic [SQ_W-1:0] r3_ea, r3_eb;
    logic [EC_W-1:0] r3_ec;

    // stage 4
    logic [EC_W-1:0] n_ecn;
    t_lin r4_lin;
    logic [OUT_RAD_W-1:0] r4_srad;
    logic [SQ_W-1:0] r4_dab;
    logic [PR_W-1:0] r4_ecm, r4_sab;

    // stage 5
    t_side r5_side;
    logic [PR_W-1:0] r5_dhh, r5_dhl, r5_dll, r5_ehh, r5_ehl, r5_ell;

    // stage 6
    t_side r6_side;
    logic [IN_RAD_W-1:0] r6_dsq, r6_esq;

    // stage 7
    t_side r7_side;
    logic [IN_RAD_W-1:0] r7_rad;

    always_comb begin
        n_sum = {i_xx[IN_W-1], i_xx} + {i_yy[IN_W-1], i_yy};
        n_rdf = {i_yx[IN_W-1], i_yx} - {i_xy[IN_W-1], i_xy};
        n_d   = {i_xx[IN_W-1], i_xx} - {i_yy[IN_W-1], i_yy};
        n_s   = {i_xy[IN_W-1], i_xy} + {i_yx[IN_W-1], i_yx};
        n_dm  = n_d[IN_W] ? (~n_d + 1'b1) : n_d;
        n_sm  = n_s[IN_W] ? (~n_s + 1'b1) : n_s;
        n_pxx = r1_xx * r1_xx;
        n_pxy = r1_xy * r1_xy;
        n_pyx = r1_yx * r1_yx;
        n_pyy = r1_yy * r1_yy;
        n_ea2 = PR_W'(r2_xx2) + PR_W'(r2_yx2);
        n_eb2 = PR_W'(r2_xy2) + PR_W'(r2_yy2);
        n_ecn = ~r3_ec + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // arithmetic halving: keep bits above the lsb of the widened sum
            r1_lin.dil <= n_sum[IN_W:1];
            r1_lin.rot <= n_rdf[IN_W:1];
            r1_dm      <= n_dm;
            r1_sm      <= n_sm;
            r1_xx      <= i_xx;
            r1_xy      <= i_xy;
            r1_yx      <= i_yx;
            r1_yy      <= i_yy;

            r2_lin <= r1_lin;
            r2_dm2 <= OUT_RAD_W'(r1_dm) * OUT_RAD_W'(r1_dm);
            r2_sm2 <= OUT_RAD_W'(r1_sm) * OUT_RAD_W'(r1_sm);
            r2_xx2 <= n_pxx[SQ_W-1:0];
            r2_xy2 <= n_pxy[SQ_W-1:0];
            r2_yx2 <= n_pyx[SQ_W-1:0];
            r2_yy2 <= n_pyy[SQ_W-1:0];
            r2_pa  <= r1_xx * r1_xy;
            r2_pb  <= r1_yx * r1_yy;

            r3_lin  <= r2_lin;
            r3_srad <= r2_dm2 + r2_sm2;
            r3_ea   <= n_ea2[PR_W-1:1];
            r3_eb   <= n_eb2[PR_W-1:1];
            r3_ec   <= {r2_pa[PR_W-1], r2_pa} + {r2_pb[PR_W-1], r2_pb};

            r4_lin  <= r3_lin;
            r4_srad <= r3_srad;
            r4_dab  <= (r3_ea > r3_eb) ? (r3_ea - r3_eb) : (r3_eb - r3_ea);
            r4_ecm  <= r3_ec[EC_W-1] ? n_ecn[PR_W-1:0] : r3_ec[PR_W-1:0];
            r4_sab  <= PR_W'(r3_ea) + PR_W'(r3_eb);

            // split wide squares into half-width partial products
            r5_side.lin       <= r4_lin;
            r5_side.shear_rad <= r4_srad;
            r5_side.sab       <= r4_sab;
            r5_dhh <= PR_W'(r4_dab[SQ_W-1:IN_W]) * PR_W'(r4_dab[SQ_W-1:IN_W]);
            r5_dhl <= PR_W'(r4_dab[SQ_W-1:IN_W]) * PR_W'(r4_dab[IN_W-1:0]);
            r5_dll <= PR_W'(r4_dab[IN_W-1:0]) * PR_W'(r4_dab[IN_W-1:0]);
            r5_ehh <= PR_W'(r4_ecm[PR_W-1:IN_W]) * PR_W'(r4_ecm[PR_W-1:IN_W]);
            r5_ehl <= PR_W'(r4_ecm[PR_W-1:IN_W]) * PR_W'(r4_ecm[IN_W-1:0]);
            r5_ell <= PR_W'(r4_ecm[IN_W-1:0]) * PR_W'(r4_ecm[IN_W-1:0]);

            r6_side <= r5_side;
            r6_dsq  <= (IN_RAD_W'(r5_dhh) << (2 * IN_W)) + (IN_RAD_W'(r5_dhl) << (IN_W + 1))
                     + IN_RAD_W'(r5_dll);
            r6_esq  <= (IN_RAD_W'(r5_ehh) << (2 * IN_W)) + (IN_RAD_W'(r5_ehl) << (IN_W + 1))
                     + IN_RAD_W'(r5_ell);

            r7_side <= r6_side;
            r7_rad  <= r6_dsq + r6_esq;
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_side  = r7_side;
    assign o_rad   = r7_rad;

endmodule

// ===== rtl/core/sgi_inner.sv =====
`timescale 1ns / 1ps
module sgi_inner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  sgi_pkg::t_side                i_side,
    input  logic [sgi_pkg::IN_RAD_W-1:0]  i_rad,
    output logic                          o_valid,
    output sgi_pkg::t_side                o_side,
    output logic [sgi_pkg::IN_ROOT_W-1:0] o_root
);
    import sgi_pkg::*;

    localparam int LAST = IN_ROOT_W - 1;

    logic [IN_ROOT_W-1:0] r_v;
    logic [IN_RAD_W-1:0]  r_rad  [IN_ROOT_W];
    t_in_acc              r_acc  [IN_ROOT_W];
    t_side                r_side [IN_ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[IN_ROOT_W-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < IN_ROOT_W; k++) begin : g_stg
        logic [IN_RAD_W-1:0] rad_in;
        t_in_acc             acc_in;
        t_side               side_in;
        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign acc_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign acc_in  = r_acc[k-1];
            assign side_in = r_side[k-1];
        end
        // consume the top two radicand bits, shift the rest up
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {rad_in[IN_RAD_W-3:0], 2'b00};
                r_acc[k]  <= in_root_step(acc_in, rad_in[IN_RAD_W-1 -: 2]);
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[LAST];
    assign o_side  = r_side[LAST];
    assign o_root  = r_acc[LAST].root;

    a_inner_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> (r_acc[LAST].rem <= {1'b0, r_acc[LAST].root, 1'b0}))
        else $error("inner root remainder exceeds twice the root");

endmodule

// ===== rtl/core/sgi_outer.sv =====
`timescale 1ns / 1ps
module sgi_outer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  sgi_pkg::t_side                 i_side,
    input  logic [sgi_pkg::IN_ROOT_W-1:0]  i_root,
    output logic                           o_valid,
    output sgi_pkg::t_lin                  o_lin,
    output logic [sgi_pkg::OUT_W-1:0]      o_max_shear,
    output logic [sgi_pkg::BND_W-1:0]      o_strain_bound
);
    import sgi_pkg::*;

    localparam int LAST = OUT_ROOT_W - 1;

    logic                  r0_v;
    t_lin                  r0_lin;
    logic [OUT_RAD_W-1:0]  r0_rad_s, r0_rad_b;

    logic [OUT_ROOT_W-1:0] r_v;
    logic [OUT_RAD_W-1:0]  r_rad_s [OUT_ROOT_W];
    logic [OUT_RAD_W-1:0]  r_rad_b [OUT_ROOT_W];
    t_out_acc              r_acc_s [OUT_ROOT_W];
    t_out_acc              r_acc_b [OUT_ROOT_W];
    t_lin                  r_lin   [OUT_ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r_v  <= '0;
        end else if (i_en) begin
            r0_v <= i_valid;
            r_v  <= {r_v[OUT_ROOT_W-2:0], r0_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_lin   <= i_side.lin;
            r0_rad_s <= i_side.shear_rad;
            r0_rad_b <= OUT_RAD_W'(i_side.sab) + OUT_RAD_W'(i_root);
        end
    end

    for (genvar k = 0; k < OUT_ROOT_W; k++) begin : g_stg
        logic [OUT_RAD_W-1:0] rs_in, rb_in;
        t_out_acc             as_in, ab_in;
        t_lin                 lin_in;
        if (k == 0) begin : g_first
            assign rs_in  = r0_rad_s;
            assign rb_in  = r0_rad_b;
            assign as_in  = '0;
            assign ab_in  = '0;
            assign lin_in = r0_lin;
        end else begin : g_next
            assign rs_in  = r_rad_s[k-1];
            assign rb_in  = r_rad_b[k-1];
            assign as_in  = r_acc_s[k-1];
            assign ab_in  = r_acc_b[k-1];
            assign lin_in = r_lin[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad_s[k] <= {rs_in[OUT_RAD_W-3:0], 2'b00};
                r_rad_b[k] <= {rb_in[OUT_RAD_W-3:0], 2'b00};
                r_acc_s[k] <= out_root_step(as_in, rs_in[OUT_RAD_W-1 -: 2]);
                r_acc_b[k] <= out_root_step(ab_in, rb_in[OUT_RAD_W-1 -: 2]);
                r_lin[k]   <= lin_in;
            end
        end
    end

    assign o_valid        = r_v[LAST];
    assign o_lin          = r_lin[LAST];
    assign o_max_shear    = r_acc_s[LAST].root[OUT_ROOT_W-1:1];
    assign o_strain_bound = r_acc_b[LAST].root;

    a_shear_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> (r_acc_s[LAST].rem <= {1'b0, r_acc_s[LAST].root, 1'b0}))
        else $error("shear root remainder exceeds twice the root");

    a_bound_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> (r_acc_b[LAST].rem <= {1'b0, r_acc_b[LAST].root, 1'b0}))
        else $error("bound root remainder exceeds twice the root");

    a_bound_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> !(o_strain_bound[BND_W-1] && (|o_strain_bound[BND_W-2:0])))
        else $error("strain bound above its largest reachable value");

endmodule

// ===== rtl/core/strain_gradient_invariants_core.sv =====
`timescale 1ns / 1ps
// 2D strain invariants: one result per input transfer, one transfer per cycle sustained while
// the output is drained. The pipeline runs the difference, square and cross-product stages,
// then the inner square root of the 128-bit radicand, then the final add and the roots of the
// two 66-bit radicands, each root stage resolving one result bit. The whole pipeline, bubbles
// included, holds while a finished result waits at the output, so input is taken only when
// the output slot is empty or being drained. No state survives between items.
module strain_gradient_invariants_core (
    input  logic i_clk,
    input  logic i_rst_n,
    sgi_in_if.sink    i_in,
    sgi_out_if.source o_out
);
    import sgi_pkg::*;

    logic                 en;
    logic                 f_valid, n_valid;
    t_side                f_side, n_side;
    logic [IN_RAD_W-1:0]  f_rad;
    logic [IN_ROOT_W-1:0] n_root;
    t_lin                 o_lin;

    // advance everything unless the output holds an untaken result
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    sgi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_xx    (i_in.grad_xx),
        .i_xy    (i_in.grad_xy),
        .i_yx    (i_in.grad_yx),
        .i_yy    (i_in.grad_yy),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_rad   (f_rad)
    );

    sgi_inner u_inner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_rad   (f_rad),
        .o_valid (n_valid),
        .o_side  (n_side),
        .o_root  (n_root)
    );

    sgi_outer u_outer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (n_valid),
        .i_side         (n_side),
        .i_root         (n_root),
        .o_valid        (o_out.valid),
        .o_lin          (o_lin),
        .o_max_shear    (o_out.max_shear),
        .o_strain_bound (o_out.strain_bound)
    );

    assign o_out.dilatation = o_lin.dil;
    assign o_out.rotation   = o_lin.rot;

endmodule
